@@ sv/scrb_pkg.sv @@
// ----------------------------------------------------------------------------
// scrb_pkg
// Shared constants, command codes and stage control type for the style color
// resolve and blend unit.
// ----------------------------------------------------------------------------
package scrb_pkg;

  // Default number of fraction bits in the blend ratios
  localparam int unsigned RATIO_FRAC_BITS_DEF = 16;

  // Color channels that go through the divider (red, green, blue)
  localparam int unsigned NUM_CHAN = 3;

  // Quotient bits per channel: eight result bits plus one saturation bit
  localparam int unsigned QUO_BITS = 9;

  // Pipeline depth: multiply/sum front end, one stage per quotient bit, output
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned LATENCY      = FRONT_STAGES + QUO_BITS + 1;

  // Command codes; any code from CMD_BLEND upward blends
  localparam logic [1:0] CMD_NUMERIC = 2'd0;
  localparam logic [1:0] CMD_CURRENT = 2'd1;
  localparam logic [1:0] CMD_BLEND   = 2'd2;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic        vld;        // stage holds an item
    logic        blend;      // item takes the blended result
    logic        zero;       // weighted alpha is zero, result is all zeros
    logic [7:0]  alpha;      // blended output alpha
    logic [31:0] pass_rgba;  // color passed through for the non-blend commands
  } scrb_ctrl_t;

endpackage

@@ sv/scrb_front.sv @@
// ----------------------------------------------------------------------------
// scrb_front
// Four-stage front end: weights the alphas, forms the premultiplied channel
// sums, clamps the weighted alpha and sets up numerator and divisor per channel.
// ----------------------------------------------------------------------------
module scrb_front
  import scrb_pkg::*;
#(
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [1:0]                             command_i,
  input  logic [31:0]                            style_rgba_i,
  input  logic [31:0]                            foreground_rgba_i,
  input  logic [RATIO_FRAC_BITS:0]               bg_weight_i,
  input  logic [RATIO_FRAC_BITS:0]               fg_weight_i,
  output scrb_ctrl_t                             ctrl_o,
  output logic [NUM_CHAN-1:0][RATIO_FRAC_BITS+19:0] num_o,
  output logic [RATIO_FRAC_BITS+19:0]            den_o
);

  localparam int unsigned WW   = RATIO_FRAC_BITS + 1;   // ratio
  localparam int unsigned WAW  = WW + 8;                 // ratio * alpha
  localparam int unsigned NAW  = WAW + 1;                // weighted alpha sum
  localparam int unsigned PW   = WAW + 8;                // ratio * alpha * channel
  localparam int unsigned NCW  = PW + 1;                 // weighted channel sum
  localparam int unsigned NUMW = RATIO_FRAC_BITS + 20;   // divider datapath

  localparam logic [NAW-1:0] SCALE = NAW'({8'd255, {RATIO_FRAC_BITS{1'b0}}});
  localparam logic [NAW-1:0] HALF  = NAW'(1) << (RATIO_FRAC_BITS - 1);

  // Stage 1: weight the alphas
  scrb_ctrl_t          ctrl1_d, ctrl1_q;
  logic [WAW-1:0]      wa1_d, wa2_d, wa1_q, wa2_q;
  logic [23:0]         c1_q, c2_q;

  always_comb begin
    ctrl1_d.vld       = accept_i;
    ctrl1_d.blend     = (command_i >= CMD_BLEND);
    ctrl1_d.zero      = 1'b0;
    ctrl1_d.alpha     = '0;
    ctrl1_d.pass_rgba = (command_i == CMD_CURRENT) ? foreground_rgba_i : style_rgba_i;
    wa1_d = WAW'(bg_weight_i) * WAW'(style_rgba_i[31:24]);
    wa2_d = WAW'(fg_weight_i) * WAW'(foreground_rgba_i[31:24]);
  end

  // Stage 2: sum the weighted alphas, weight each channel
  scrb_ctrl_t                  ctrl2_q;
  logic [NAW-1:0]              na2_d, na2_q;
  logic [NUM_CHAN-1:0][PW-1:0] pr1_d, pr2_d, pr1_q, pr2_q;

  always_comb begin
    na2_d = NAW'(wa1_q) + NAW'(wa2_q);
    for (int i = 0; i < NUM_CHAN; i++) begin
      pr1_d[i] = PW'(wa1_q) * PW'(c1_q[8*i +: 8]);
      pr2_d[i] = PW'(wa2_q) * PW'(c2_q[8*i +: 8]);
    end
  end

  // Stage 3: channel sums, clamp alpha to one, round output alpha
  scrb_ctrl_t                   ctrl3_d, ctrl3_q;
  logic [NUM_CHAN-1:0][NCW-1:0] nc3_d, nc3_q;
  logic [NAW-1:0]               d3_d, d3_q;
  logic [NAW:0]                 a_rnd, a_shr;

  always_comb begin
    ctrl3_d      = ctrl2_q;
    ctrl3_d.zero = (na2_q == '0);
    a_rnd        = {1'b0, na2_q} + {1'b0, HALF};
    a_shr        = a_rnd >> RATIO_FRAC_BITS;
    if (na2_q > SCALE) begin
      d3_d          = SCALE;
      ctrl3_d.alpha = 8'hFF;
    end else begin
      d3_d          = na2_q;
      ctrl3_d.alpha = (a_shr > (NAW+1)'(255)) ? 8'hFF : a_shr[7:0];
    end
    for (int i = 0; i < NUM_CHAN; i++) begin
      nc3_d[i] = NCW'(pr1_q[i]) + NCW'(pr2_q[i]);
    end
  end

  // Stage 4: rounding numerator 2*nc + d and divisor 2*d
  scrb_ctrl_t                    ctrl4_q;
  logic [NUM_CHAN-1:0][NUMW-1:0] num4_d, num4_q;
  logic [NUMW-1:0]               den4_d, den4_q;

  always_comb begin
    den4_d = NUMW'(d3_q) << 1;
    for (int i = 0; i < NUM_CHAN; i++) begin
      num4_d[i] = (NUMW'(nc3_q[i]) << 1) + NUMW'(d3_q);
    end
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
    end else begin
      ctrl1_q <= ctrl1_d;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl3_d;
      ctrl4_q <= ctrl3_q;
    end
  end

  // Advance datapath
  always_ff @(posedge clk_i) begin
    wa1_q  <= wa1_d;
    wa2_q  <= wa2_d;
    c1_q   <= style_rgba_i[23:0];
    c2_q   <= foreground_rgba_i[23:0];
    na2_q  <= na2_d;
    pr1_q  <= pr1_d;
    pr2_q  <= pr2_d;
    nc3_q  <= nc3_d;
    d3_q   <= d3_d;
    num4_q <= num4_d;
    den4_q <= den4_d;
  end

  assign ctrl_o = ctrl4_q;
  assign num_o  = num4_q;
  assign den_o  = den4_q;

endmodule

@@ sv/scrb_div_step.sv @@
// ----------------------------------------------------------------------------
// scrb_div_step
// One registered restoring-division step: resolves one quotient bit for each
// color channel.
// ----------------------------------------------------------------------------
module scrb_div_step
  import scrb_pkg::*;
#(
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
  parameter int unsigned BIT_IDX         = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  scrb_ctrl_t                                ctrl_i,
  input  logic [NUM_CHAN-1:0][RATIO_FRAC_BITS+19:0] num_i,
  input  logic [RATIO_FRAC_BITS+19:0]               den_i,
  input  logic [NUM_CHAN-1:0][QUO_BITS-1:0]         quo_i,
  output scrb_ctrl_t                                ctrl_o,
  output logic [NUM_CHAN-1:0][RATIO_FRAC_BITS+19:0] num_o,
  output logic [RATIO_FRAC_BITS+19:0]               den_o,
  output logic [NUM_CHAN-1:0][QUO_BITS-1:0]         quo_o
);

  localparam int unsigned NUMW = RATIO_FRAC_BITS + 20;

  scrb_ctrl_t                        ctrl_q;
  logic [NUMW-1:0]                   dsh;
  logic [NUM_CHAN-1:0]               ge;
  logic [NUM_CHAN-1:0][NUMW-1:0]     num_d, num_q;
  logic [NUMW-1:0]                   den_q;
  logic [NUM_CHAN-1:0][QUO_BITS-1:0] quo_d, quo_q;

  // Compare against the shifted divisor and subtract on a hit
  always_comb begin
    dsh = den_i << BIT_IDX;
    for (int c = 0; c < NUM_CHAN; c++) begin
      ge[c]             = (num_i[c] >= dsh);
      num_d[c]          = ge[c] ? (num_i[c] - dsh) : num_i[c];
      quo_d[c]          = quo_i[c];
      quo_d[c][BIT_IDX] = ge[c];
    end
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance datapath
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_i;
    quo_q <= quo_d;
  end

  assign ctrl_o = ctrl_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;

endmodule

@@ sv/style_color_resolve_blend_unit.sv @@
// ----------------------------------------------------------------------------
// style_color_resolve_blend_unit
// Resolves a style color to RGBA: stored color, foreground color, or a
// premultiplied-alpha blend of the two with rounding and saturation.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle and never raises busy_o, so
// start_i may be held high continuously. Each item returns its result with a
// one-cycle done_o strobe, in order, for all three commands. Each item passes
// through four multiply and sum stages, a nine-stage restoring divider that
// resolves one quotient bit per stage for red, green and blue in parallel
// (the top bit detects saturation at 255), and one output register. The
// receiver must take each result in its strobe cycle.
module style_color_resolve_blend_unit
  import scrb_pkg::*;
#(
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 command_i,
  input  logic [31:0]                style_rgba_i,
  input  logic [31:0]                foreground_rgba_i,
  input  logic [RATIO_FRAC_BITS:0]   bg_weight_i,
  input  logic [RATIO_FRAC_BITS:0]   fg_weight_i,
  output logic                       done_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [7:0]                 alpha_o
);

  localparam int unsigned NUMW = RATIO_FRAC_BITS + 20;

  logic accept;

  scrb_ctrl_t                        ctrl_s [QUO_BITS+1];
  logic [NUM_CHAN-1:0][NUMW-1:0]     num_s  [QUO_BITS+1];
  logic [NUMW-1:0]                   den_s  [QUO_BITS+1];
  logic [NUM_CHAN-1:0][QUO_BITS-1:0] quo_s  [QUO_BITS+1];

  // The pipeline never stalls
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Front end: weights, sums, alpha clamp
  scrb_front #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .command_i         (command_i),
    .style_rgba_i      (style_rgba_i),
    .foreground_rgba_i (foreground_rgba_i),
    .bg_weight_i       (bg_weight_i),
    .fg_weight_i       (fg_weight_i),
    .ctrl_o            (ctrl_s[0]),
    .num_o             (num_s[0]),
    .den_o             (den_s[0])
  );

  assign quo_s[0] = '0;

  // Divider: saturation bit first, then result bits MSB to LSB
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    scrb_div_step #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
      .BIT_IDX         (QUO_BITS - 1 - k)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_s[k]),
      .num_i  (num_s[k]),
      .den_i  (den_s[k]),
      .quo_i  (quo_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .num_o  (num_s[k+1]),
      .den_o  (den_s[k+1]),
      .quo_o  (quo_s[k+1])
    );
  end

  // Select the result: pass-through, zero alpha, or saturated quotient
  scrb_ctrl_t                    ctrl_f;
  logic [NUM_CHAN-1:0][7:0]      chan_d;
  logic [7:0]                    alpha_d;
  logic                          done_q;
  logic [NUM_CHAN-1:0][7:0]      chan_q;
  logic [7:0]                    alpha_q;

  assign ctrl_f = ctrl_s[QUO_BITS];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (!ctrl_f.blend) begin
        chan_d[c] = ctrl_f.pass_rgba[8*c +: 8];
      end else if (ctrl_f.zero) begin
        chan_d[c] = '0;
      end else if (quo_s[QUO_BITS][c][QUO_BITS-1]) begin
        chan_d[c] = 8'hFF;
      end else begin
        chan_d[c] = quo_s[QUO_BITS][c][7:0];
      end
    end
    if (!ctrl_f.blend) begin
      alpha_d = ctrl_f.pass_rgba[31:24];
    end else if (ctrl_f.zero) begin
      alpha_d = '0;
    end else begin
      alpha_d = ctrl_f.alpha;
    end
  end

  // Hold the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_f.vld;
    end
  end

  // Hold the result
  always_ff @(posedge clk_i) begin
    chan_q  <= chan_d;
    alpha_q <= alpha_d;
  end

  assign done_o  = done_q;
  assign red_o   = chan_q[0];
  assign green_o = chan_q[1];
  assign blue_o  = chan_q[2];
  assign alpha_o = alpha_q;

endmodule

@@ sv/scrb_checker.sv @@
// ----------------------------------------------------------------------------
// scrb_assert_checker
// Port-level checks for the style color resolve and blend unit: fixed result
// latency, pass-through commands and the zero-alpha blend.
// ----------------------------------------------------------------------------
module scrb_assert_checker
  import scrb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  command_i,
  input logic [31:0] style_rgba_i,
  input logic [31:0] foreground_rgba_i,
  input logic        done_o,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  alpha_o
);

  // Every item returns its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("item result missing at fixed latency");

  // Numeric command returns the stored color unchanged
  a_numeric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_NUMERIC) |-> ##LATENCY
      (red_o == $past(style_rgba_i[7:0], LATENCY) &&
       green_o == $past(style_rgba_i[15:8], LATENCY) &&
       blue_o == $past(style_rgba_i[23:16], LATENCY) &&
       alpha_o == $past(style_rgba_i[31:24], LATENCY)))
    else $error("numeric item did not pass the stored color");

  // Current-color command returns the foreground color unchanged
  a_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_CURRENT) |-> ##LATENCY
      (red_o == $past(foreground_rgba_i[7:0], LATENCY) &&
       green_o == $past(foreground_rgba_i[15:8], LATENCY) &&
       blue_o == $past(foreground_rgba_i[23:16], LATENCY) &&
       alpha_o == $past(foreground_rgba_i[31:24], LATENCY)))
    else $error("current-color item did not pass the foreground color");

  // Blend of two fully transparent colors is all zeros
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != CMD_NUMERIC && command_i != CMD_CURRENT &&
     style_rgba_i[31:24] == 8'd0 && foreground_rgba_i[31:24] == 8'd0) |-> ##LATENCY
      (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0 && alpha_o == 8'd0))
    else $error("transparent blend did not give zeros");

endmodule

bind style_color_resolve_blend_unit scrb_assert_checker u_scrb_assert_checker (.*);
